@@ sv/tkn_pkg.sv @@
// ----------------------------------------------------------------------------
// tkn_pkg
// Shared types, widths and the ranking function for the newest-message
// selector and its cells.
// ----------------------------------------------------------------------------
package tkn_pkg;

    localparam int unsigned REF_W  = 32;
    localparam int unsigned ID_W   = 63;
    localparam int unsigned DATE_W = 48;

    // One held candidate, packed so the first stream field sits lowest.
    typedef struct packed {
        logic              is_post;
        logic [DATE_W-1:0] msg_date;
        logic [ID_W-1:0]   msg_id;
        logic [REF_W-1:0]  message_ref;
        logic [REF_W-1:0]  person_ref;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // Item kinds carried on the input tuser bit.
    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } state_t;

    // True when the candidate ranks strictly better than the held entry:
    // newer date first, then smaller message id.
    function automatic logic better(input entry_t cand, input entry_t held);
        logic res;
        if (cand.msg_date != held.msg_date)
        begin
            res = (cand.msg_date > held.msg_date);
        end
        else
        begin
            res = (cand.msg_id < held.msg_id);
        end
        return res;
    endfunction

endpackage

@@ sv/tkn_cell.sv @@
// ----------------------------------------------------------------------------
// tkn_cell
// One slot of the sorted chain. It compares the offered item with its own
// entry and either keeps it, takes the item, or takes its upper neighbor's
// entry; during a flush it takes its lower neighbor's entry.
// ----------------------------------------------------------------------------
module tkn_cell (
    input  logic            clk,
    input  logic            occupied,
    input  logic            insert,
    input  logic            pop,
    input  tkn_pkg::entry_t offer,
    input  tkn_pkg::entry_t up_entry,
    input  logic            up_beats,
    input  tkn_pkg::entry_t down_entry,
    output tkn_pkg::entry_t entry,
    output logic            beats
);

    tkn_pkg::entry_t entry_reg;
    tkn_pkg::entry_t entry_next;

    // An empty slot is beaten by any offer.
    assign beats = !occupied || tkn_pkg::better(offer, entry_reg);

    // Shift down on insert, shift up on pop.
    always_comb
    begin
        entry_next = entry_reg;
        if (pop)
        begin
            entry_next = down_entry;
        end
        else if (insert && beats)
        begin
            entry_next = up_beats ? up_entry : offer;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ sv/top_k_newest_message_select.sv @@
// ----------------------------------------------------------------------------
// top_k_newest_message_select
// Keeps the TOP_N newest message candidates in a sorted chain of cells and
// emits them best first on a flush.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_t*. tuser is the kind: offer or flush. For an
//   offer every cell compares it with its entry in parallel and the chain
//   shifts down one place below the insertion point, so offers stream at one
//   per cycle while no flush drains, with no result.
//   A flush makes the chain shift toward cell 0, one entry per cycle while
//   the output register is free, so a flush of n held entries gives n results
//   (an empty table gives one result with tuser low). No input is taken while
//   a flush drains; the next item is taken in the cycle after the last result
//   enters the output register, even if it is still waiting.
//   m_tlast marks the final result of a flush, m_tuser says it holds an entry.
//   If the receiver stalls in a flush, the chain holds and the output stays.
//   cfg_data sets max_date (always ready); write it only while idle.
//   Reset empties the table and sets max_date to all ones.
// ----------------------------------------------------------------------------
module top_k_newest_message_select #(
    parameter int unsigned TOP_N = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    // tdata: person_ref, message_ref, message_id, creation_date, is_post
    input  logic [175:0] s_tdata,
    // tuser: kind
    input  logic         s_tuser,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: out_person_ref, out_message_ref, out_message_id,
    //        out_creation_date, out_is_post
    output logic [175:0] m_tdata,
    // tuser: valid_res
    output logic         m_tuser,
    output logic         m_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  cfg_data,
    input  logic         cfg_valid,
    output logic         cfg_ready
);

    localparam int unsigned COUNT_W = $clog2(TOP_N + 1);

    tkn_pkg::state_t state_reg, state_next;
    logic [COUNT_W-1:0] fill_reg, fill_next;
    logic [tkn_pkg::DATE_W-1:0] max_date_reg;
    tkn_pkg::entry_t out_entry_reg, out_entry_next;
    logic out_valid_reg, out_valid_next;
    logic out_res_reg, out_res_next;
    logic out_last_reg, out_last_next;

    tkn_pkg::entry_t offer;
    tkn_pkg::entry_t cell_entry [TOP_N];
    logic [TOP_N-1:0] cell_beats;
    logic s_accept, insert, pop, out_free;

    assign offer     = tkn_pkg::entry_t'(s_tdata[tkn_pkg::ENTRY_W-1:0]);
    assign s_tready  = (state_reg == tkn_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign insert    = s_accept && (s_tuser == tkn_pkg::KIND_OFFER) &&
                       (offer.msg_date <= max_date_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign pop       = (state_reg == tkn_pkg::ST_FLUSH) && out_free;
    assign cfg_ready = 1'b1;

    // Chain of cells; cell 0 holds the best entry.
    for (genvar k = 0; k < TOP_N; k++)
    begin : g_cell
        tkn_pkg::entry_t up_e, down_e;
        logic up_b;
        if (k == 0)
        begin : g_head
            assign up_e = offer;
            assign up_b = 1'b0;
        end
        else
        begin : g_body
            assign up_e = cell_entry[k-1];
            assign up_b = cell_beats[k-1];
        end
        if (k == TOP_N - 1)
        begin : g_tail
            assign down_e = offer;
        end
        else
        begin : g_mid
            assign down_e = cell_entry[k+1];
        end
        tkn_cell u_cell (
            .clk        (clk),
            .occupied   (COUNT_W'(k) < fill_reg),
            .insert     (insert),
            .pop        (pop),
            .offer      (offer),
            .up_entry   (up_e),
            .up_beats   (up_b),
            .down_entry (down_e),
            .entry      (cell_entry[k]),
            .beats      (cell_beats[k])
        );
    end

    // Control, fill count and output register loading.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        out_entry_next = out_entry_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_res_next   = out_res_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            tkn_pkg::ST_IDLE:
            begin
                if (s_accept && (s_tuser == tkn_pkg::KIND_FLUSH))
                begin
                    state_next = tkn_pkg::ST_FLUSH;
                end
                else if (insert && (fill_reg < COUNT_W'(TOP_N)))
                begin
                    fill_next = fill_reg + COUNT_W'(1);
                end
            end
            tkn_pkg::ST_FLUSH:
            begin
                if (pop)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = (fill_reg != '0);
                    out_last_next  = (fill_reg <= COUNT_W'(1));
                    out_entry_next = (fill_reg != '0) ? cell_entry[0] : '0;
                    if (fill_reg <= COUNT_W'(1))
                    begin
                        state_next = tkn_pkg::ST_IDLE;
                        fill_next  = '0;
                    end
                    else
                    begin
                        fill_next = fill_reg - COUNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = tkn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tkn_pkg::ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            max_date_reg  <= '1;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_date_reg <= cfg_data;
            end
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_entry_reg <= out_entry_next;
        out_res_reg   <= out_res_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_entry_reg;
    assign m_tuser  = out_res_reg;
    assign m_tlast  = out_last_reg;

    // The fill count never passes the table size.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= COUNT_W'(TOP_N))
        else $error("fill count above table size");

    // A result without an entry only comes from an empty flush, so it is last.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("empty result not marked last");

    // An accepted offer into a table with room grows the fill count by one.
    a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (insert && (fill_reg < COUNT_W'(TOP_N))) |=>
        (fill_reg == $past(fill_reg) + COUNT_W'(1)))
        else $error("offer did not grow the table");

    // A flush drains: each pop lowers the count until the last result.
    a_flush_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (fill_reg > COUNT_W'(1))) |=>
        ((state_reg == tkn_pkg::ST_FLUSH) && (fill_reg == $past(fill_reg) - COUNT_W'(1))))
        else $error("flush drain step wrong");

endmodule
